>>> hdl/stdg_pkg.sv
// Package for the square tone envelope generator.
// Holds widths, register indexes, reset values and the sequencer state type.
// No dependencies.
package stdg_pkg;

  // Default core widths
  localparam int PHASE_BITS_DEF  = 32;
  localparam int LENGTH_BITS_DEF = 20;

  // Field and register widths
  localparam int PEAK_W     = 15;
  localparam int PCT_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int QUOT_W     = PEAK_W;   // envelope quotient never exceeds peak
  localparam int MUL_X_W    = PEAK_W;   // narrow operand of the shared multiplier

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

  // Register reset values
  localparam logic [PEAK_W-1:0] PEAK_RST    = 15'd13107;
  localparam logic [PCT_W-1:0]  ATTACK_RST  = 7'd5;
  localparam logic [PCT_W-1:0]  RELEASE_RST = 7'd15;

  // Full scale of a percentage
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MI   = 10'b00_0000_0010,  // index * 100
    S_MA   = 10'b00_0000_0100,  // attack * length
    S_MT   = 10'b00_0000_1000,  // (100 - release) * length
    S_MR   = 10'b00_0001_0000,  // release * length
    S_ML   = 10'b00_0010_0000,  // length * 100
    S_DEC  = 10'b00_0100_0000,  // pick envelope segment, advance phase
    S_MP   = 10'b00_1000_0000,  // peak * numerator, start divide
    S_DIV  = 10'b01_0000_0000,  // wait for divider
    S_OUT  = 10'b10_0000_0000   // hand result to output register
  } state_t;

endpackage

>>> hdl/square_tone_envelope_generator_unit.sv
// Top level of the square tone envelope generator.
// Depends on stdg_pkg and stdg_div.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tdata: phase_step, note_length; tuser: start_req
//  out_    | output    | out_tvalid/tready  | tdata: sample; tuser: active
//  cfg_    | input     | cfg_valid/ready    | cfg_index, cfg_data
//
// A sample tick runs through the five products and the segment pick; on the
// flat part of the envelope or after the note ends it goes straight to the
// output, and on an attack or release ramp it first waits for the restoring
// divider (15 steps). All products go through one shared multiplier, one per
// cycle. in_tready is high only while the sequencer idles. A finished result
// waits in the output register; the next tick is accepted meanwhile and stalls
// only when its own result is ready. Reset is synchronous.
module square_tone_envelope_generator_unit #(
  parameter int PHASE_BITS  = stdg_pkg::PHASE_BITS_DEF,
  parameter int LENGTH_BITS = stdg_pkg::LENGTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: phase_step [PHASE_BITS-1:0], note_length above it, zero padding
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((PHASE_BITS+LENGTH_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: start_req
  input  logic                                   in_tuser,
  // out_tdata: sample
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [stdg_pkg::SAMPLE_W-1:0]          out_tdata,
  // out_tuser: active
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [stdg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [stdg_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import stdg_pkg::*;

  localparam int VW = LENGTH_BITS + PCT_W;   // holds a length times 100
  localparam int PW = MUL_X_W + VW;          // full product width

  state_t state_r;

  // Configuration
  logic [PEAK_W-1:0] peak_r;
  logic [PCT_W-1:0]  att_r;
  logic [PCT_W-1:0]  rel_r;
  logic [PCT_W-1:0]  att_eff;
  logic [PCT_W-1:0]  rel_eff;

  // Note state
  logic [PHASE_BITS-1:0]  phase_r;
  logic [PHASE_BITS-1:0]  step_r;
  logic [LENGTH_BITS-1:0] idx_r;
  logic [LENGTH_BITS-1:0] len_r;

  // Working values
  logic [VW-1:0]     ni_r;     // index * 100
  logic [VW-1:0]     da_r;     // attack * length
  logic [VW-1:0]     thr_r;    // (100 - release) * length
  logic [VW-1:0]     dr_r;     // release * length
  logic [VW-1:0]     l100_r;   // length * 100
  logic [VW-1:0]     num_r;
  logic [VW-1:0]     den_r;
  logic [PEAK_W-1:0] mag_r;
  logic              neg_r;
  logic              act_r;

  // Output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_active_r;

  // Shared multiplier
  logic [MUL_X_W-1:0] mul_x;
  logic [VW-1:0]      mul_y;
  logic [PW-1:0]      prod;

  logic              in_req;
  logic              out_free;
  logic              note_over;
  logic              in_attack;
  logic              in_release;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  assign in_tready = (state_r == S_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Percentages above full scale count as full scale
  assign att_eff = (att_r > PCT_FULL) ? PCT_FULL : att_r;
  assign rel_eff = (rel_r > PCT_FULL) ? PCT_FULL : rel_r;

  assign note_over  = idx_r >= len_r;
  assign in_attack  = ni_r < da_r;
  assign in_release = ni_r > thr_r;

  // Operand selection for the multiplier
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state_r)
      S_MI: begin
        mul_x = MUL_X_W'(PCT_FULL);
        mul_y = VW'(idx_r);
      end
      S_MA: begin
        mul_x = MUL_X_W'(att_eff);
        mul_y = VW'(len_r);
      end
      S_MT: begin
        mul_x = MUL_X_W'(PCT_FULL - rel_eff);
        mul_y = VW'(len_r);
      end
      S_MR: begin
        mul_x = MUL_X_W'(rel_eff);
        mul_y = VW'(len_r);
      end
      S_ML: begin
        mul_x = MUL_X_W'(PCT_FULL);
        mul_y = VW'(len_r);
      end
      S_MP: begin
        mul_x = peak_r;
        mul_y = num_r;
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_x) * PW'(mul_y);

  // Envelope divide: peak * numerator / denominator
  stdg_div #(
    .NUM_W  (PW),
    .DEN_W  (VW),
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_MP),
    .num   (prod),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer, note state, configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= PEAK_RST;
      att_r       <= ATTACK_RST;
      rel_r       <= RELEASE_RST;
      phase_r     <= '0;
      step_r      <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PEAK:    peak_r <= cfg_data[PEAK_W-1:0];
          CFG_ATTACK:  att_r  <= cfg_data[PCT_W-1:0];
          CFG_RELEASE: rel_r  <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end

      // Output valid: load a finished sample, drop once taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_req) begin
            if (in_tuser) begin
              step_r  <= in_tdata[PHASE_BITS-1:0];
              len_r   <= in_tdata[PHASE_BITS+LENGTH_BITS-1:PHASE_BITS];
              phase_r <= '0;
              idx_r   <= '0;
            end
            state_r <= S_MI;
          end
        end
        S_MI: state_r <= S_MA;
        S_MA: state_r <= S_MT;
        S_MT: state_r <= S_MR;
        S_MR: state_r <= S_ML;
        S_ML: state_r <= S_DEC;
        S_DEC: begin
          if (note_over) begin
            state_r <= S_OUT;
          end else begin
            phase_r <= phase_r + step_r;
            idx_r   <= idx_r + 1'b1;
            state_r <= (in_attack || in_release) ? S_MP : S_OUT;
          end
        end
        S_MP: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working values and output payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_MI: ni_r   <= prod[VW-1:0];
      S_MA: da_r   <= prod[VW-1:0];
      S_MT: thr_r  <= prod[VW-1:0];
      S_MR: dr_r   <= prod[VW-1:0];
      S_ML: l100_r <= prod[VW-1:0];
      S_DEC: begin
        act_r <= !note_over;
        if (note_over) begin
          mag_r <= '0;
          neg_r <= 1'b0;
        end else begin
          mag_r <= peak_r;
          neg_r <= phase_r[PHASE_BITS-1];
          if (in_attack) begin
            num_r <= ni_r;
            den_r <= da_r;
          end else begin
            num_r <= l100_r - ni_r;
            den_r <= dr_r;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mag_r <= div_quot;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_sample_r <= neg_r ? (SAMPLE_W'(0) - SAMPLE_W'(mag_r)) : SAMPLE_W'(mag_r);
          out_active_r <= act_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_active_r;

endmodule

>>> hdl/stdg_div.sv
// Restoring divider for the envelope magnitude, one quotient bit per cycle.
// Needs num < den * 2^QUOT_W. Depends on nothing outside this file.
module stdg_div #(
  parameter int NUM_W  = 46,
  parameter int DEN_W  = 27,
  parameter int QUOT_W = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int CW = $clog2(QUOT_W);

  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dsh_r;
  logic [QUOT_W-1:0] q_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              fits;

  assign fits = rem_r >= dsh_r;

  // Control: busy flag and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QUOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: compare and subtract the shifted divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= NUM_W'(den) << (QUOT_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QUOT_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> hdl/stdg_chk.sv
// Port-level checks for the square tone envelope generator.
// Depends on square_tone_envelope_generator_unit; bound to it below.
module stdg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result holds its sample
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // An inactive tick carries a zero sample
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0)
    else $error("inactive sample not zero");

  // One tick at a time: busy right after a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // Register writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind square_tone_envelope_generator_unit stdg_chk u_stdg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

>>> sim/tb.sv
// Self-checking bench for square_tone_envelope_generator_unit: random sample ticks and
// register writes, with an in-bench tone model predicting every sample.
// Depends on stdg_pkg and the RTL under hdl/.
module tb;
  import stdg_pkg::*;

  localparam int PHASE_W   = PHASE_BITS_DEF;
  localparam int LEN_W     = LENGTH_BITS_DEF;
  localparam int TDATA_W   = ((PHASE_W + LEN_W + 7) / 8) * 8;
  localparam int SETTLE    = 40;     // cycles after the last sample, above ramp latency
  localparam int LONG_HOLD = 200;    // one long receiver stall
  localparam int PHASE_TICKS = 125;  // minimum ticks per register setting
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic              start;
    logic [PHASE_W-1:0] step;
    logic [LEN_W-1:0]   len;
  } tick_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                active;
  } sample_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  square_tone_envelope_generator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Pending ticks and expected samples
  tick_t   tick_q[$];
  sample_t sample_q[$];
  int      errors = 0;
  int      ticks_sent = 0;
  int      queued = 0;

  // Tone model: registers and note state
  logic [PEAK_W-1:0]  reg_peak    = PEAK_RST;
  logic [PCT_W-1:0]   reg_attack  = ATTACK_RST;
  logic [PCT_W-1:0]   reg_release = RELEASE_RST;
  logic [PHASE_W-1:0] tone_phase = '0;
  logic [LEN_W-1:0]   tone_index = '0;
  logic [PHASE_W-1:0] tone_step  = '0;
  logic [LEN_W-1:0]   tone_len   = '0;

  // Driver and receiver pacing
  tick_t       cur_tick;
  int unsigned send_gap = 0;
  int unsigned send_burst = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_burst = 0;
  bit          long_hold_done = 1'b0;
  sample_t     want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // One sample tick of the enveloped square tone; advances the note state
  function automatic sample_t predict_sample(input tick_t t);
    longint unsigned a, r, pk, i, len, mag;
    sample_t s;
    if (t.start) begin
      tone_step  = t.step;
      tone_len   = t.len;
      tone_phase = '0;
      tone_index = '0;
    end
    s.sample = '0;
    s.active = 1'b0;
    if (tone_index >= tone_len) return s;
    a   = (reg_attack > PCT_FULL) ? 64'(PCT_FULL) : 64'(reg_attack);
    r   = (reg_release > PCT_FULL) ? 64'(PCT_FULL) : 64'(reg_release);
    pk  = 64'(reg_peak);
    i   = 64'(tone_index);
    len = 64'(tone_len);
    if (i * 100 < a * len)
      mag = (pk * i * 100) / (a * len);
    else if (i * 100 > (100 - r) * len)
      mag = (pk * (len - i) * 100) / (r * len);
    else
      mag = pk;
    s.sample = tone_phase[PHASE_W-1] ? SAMPLE_W'(64'd0 - mag) : SAMPLE_W'(mag);
    s.active = 1'b1;
    tone_phase = tone_phase + tone_step;
    tone_index = tone_index + 1'b1;
    return s;
  endfunction

  // Idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 8) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Driver: offers queued ticks, records a prediction per accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sample_q.push_back(predict_sample(cur_tick));
        ticks_sent <= ticks_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          cur_tick = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_tick.start;
          in_tdata  <= {{(TDATA_W-PHASE_W-LEN_W){1'b0}}, cur_tick.len, cur_tick.step};
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else begin
            send_gap = idle_len();
            if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 80);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, one long hold once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!long_hold_done && ticks_sent >= 400) begin
      long_hold_done = 1'b1;
      recv_stall = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (recv_burst > 0) begin
        recv_burst--;
        recv_stall = 0;
      end else begin
        recv_stall = idle_len();
        if ($urandom_range(0, 49) == 0) recv_burst = $urandom_range(20, 80);
      end
    end
  end

  // Monitor: compare each sample with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sample_q.size() == 0) begin
        $error("sample with no tick pending: sample=%0d active=%0b",
               $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        want = sample_q.pop_front();
        if (out_tdata !== want.sample) begin
          $error("sample mismatch: expected %0d, got %0d",
                 $signed(want.sample), $signed(out_tdata));
          errors++;
        end
        if (out_tuser !== want.active) begin
          $error("active mismatch: expected %0b, got %0b", want.active, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic push_tick(input bit start, input logic [PHASE_W-1:0] step,
                           input logic [LEN_W-1:0] len);
    tick_t t;
    t.start = start;
    t.step  = step;
    t.len   = len;
    tick_q.push_back(t);
    queued++;
  endtask

  // One register write request; model follows on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PEAK:    reg_peak    = val[PEAK_W-1:0];
      CFG_ATTACK:  reg_attack  = val[PCT_W-1:0];
      CFG_RELEASE: reg_release = val[PCT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: everything delivered, then let the sequencer settle;
  // checked between edges so that the driver's updates have landed
  task automatic wait_idle();
    while (tick_q.size() != 0 || in_tvalid || sample_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_pct();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return CFG_DATA_W'($urandom_range(101, 127));
    return CFG_DATA_W'($urandom_range(1, 60));
  endfunction

  // A note start followed by its ticks; sometimes cut short by the next note
  task automatic add_phrase();
    logic [PHASE_W-1:0] step;
    logic [LEN_W-1:0]   len;
    int unsigned roll, n;
    roll = $urandom_range(0, 9);
    step = (roll == 0) ? '0 : (roll == 1) ? {1'b1, {(PHASE_W-1){1'b0}}} : PHASE_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 80) len = LEN_W'($urandom_range(1, 40));
    else if (roll < 88) len = LEN_W'($urandom_range(41, 200));
    else if (roll < 92) len = '0;
    else len = LEN_W'($urandom);
    if (len > 200) n = $urandom_range(10, 60);
    else if (len == 0) n = $urandom_range(0, 2);
    else n = 32'(len) - 1 + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
    push_tick(1'b1, step, len);
    repeat (n) push_tick(1'b0, PHASE_W'($urandom), LEN_W'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle generator, zero length, a short note through its end, widest note
    push_tick(1'b0, PHASE_W'($urandom), LEN_W'($urandom));
    push_tick(1'b1, '1, '0);
    push_tick(1'b1, {1'b1, {(PHASE_W-1){1'b0}}}, LEN_W'(20));
    repeat (20) push_tick(1'b0, PHASE_W'($urandom), LEN_W'($urandom));
    push_tick(1'b1, '1, '1);
    push_tick(1'b0, '0, '0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;  // reset values
        1: begin
          write_reg(CFG_PEAK, 15'd32767);
          write_reg(CFG_ATTACK, 15'd0);
          write_reg(CFG_RELEASE, 15'd0);
        end
        2: begin
          write_reg(CFG_PEAK, 15'd0);
          write_reg(CFG_ATTACK, 15'd100);
          write_reg(CFG_RELEASE, 15'd100);
        end
        3: begin
          write_reg(CFG_PEAK, 15'd32767);
          write_reg(CFG_ATTACK, 15'd127);
          write_reg(CFG_RELEASE, 15'd127);
        end
        4: begin
          write_reg(CFG_PEAK, 15'd1);
          write_reg(CFG_ATTACK, 15'd100);
          write_reg(CFG_RELEASE, 15'd0);
        end
        default: begin
          write_reg(CFG_PEAK, CFG_DATA_W'($urandom_range(0, 32767)));
          write_reg(CFG_ATTACK, pick_pct());
          write_reg(CFG_RELEASE, pick_pct());
        end
      endcase
      queued = 0;
      while (queued < PHASE_TICKS) begin
        // stray tick now and then, otherwise a full note
        if ($urandom_range(0, 19) == 0)
          push_tick(1'($urandom_range(0, 1)), PHASE_W'($urandom), LEN_W'($urandom));
        else add_phrase();
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
